>>> design/sme_pkg.sv
// Shared types and constants for the stack machine execute unit.
package sme_pkg;

  localparam int STACK_ENTRIES_DEF = 64;
  localparam int WORD_W            = 32;

  // Decoded operation classes handed from the front end to the back end.
  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_PUSH,
    OP_POP,
    OP_DUPE,
    OP_LOAD,
    OP_STORE,
    OP_JUMP,
    OP_IFZERO,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_DIV_ZERO  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_BAD_INDEX = 3'd4,
    ERR_HALTED    = 3'd5
  } err_t;

  typedef struct packed {
    logic [3:0]               command;
    logic signed [WORD_W-1:0] argument;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic signed [WORD_W-1:0] popped_value;
    logic                     branch_taken;
    logic signed [WORD_W-1:0] branch_offset;
    logic [6:0]               stack_depth;
    logic [2:0]               error_code;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] arg;
  } dec_item_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/sme_front.sv
// Front end: accepts instructions, decodes the command and queues them for execution.
module sme_front import sme_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      q_valid,
  output dec_item_t q_item,
  input  logic      q_pop
);

  localparam logic [3:0] CMD_ADD    = 4'd0;
  localparam logic [3:0] CMD_SUB    = 4'd1;
  localparam logic [3:0] CMD_MUL    = 4'd2;
  localparam logic [3:0] CMD_DIV    = 4'd3;
  localparam logic [3:0] CMD_PUSH   = 4'd4;
  localparam logic [3:0] CMD_POP    = 4'd5;
  localparam logic [3:0] CMD_DUPE   = 4'd6;
  localparam logic [3:0] CMD_LOAD   = 4'd7;
  localparam logic [3:0] CMD_STORE  = 4'd8;
  localparam logic [3:0] CMD_JUMP   = 4'd9;
  localparam logic [3:0] CMD_IFZERO = 4'd10;

  dec_item_t  queue_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  op_t        dec_op;

  always_comb begin
    unique case (in_item.command)
      CMD_ADD:    dec_op = OP_ADD;
      CMD_SUB:    dec_op = OP_SUB;
      CMD_MUL:    dec_op = OP_MUL;
      CMD_DIV:    dec_op = OP_DIV;
      CMD_PUSH:   dec_op = OP_PUSH;
      CMD_POP:    dec_op = OP_POP;
      CMD_DUPE:   dec_op = OP_DUPE;
      CMD_LOAD:   dec_op = OP_LOAD;
      CMD_STORE:  dec_op = OP_STORE;
      CMD_JUMP:   dec_op = OP_JUMP;
      CMD_IFZERO: dec_op = OP_IFZERO;
      default:    dec_op = OP_NOP;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = queue_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{op: dec_op, arg: in_item.argument};
    end
  end

endmodule

>>> design/sme_div.sv
// Radix-2 restoring divider for signed 32-bit division truncating toward zero.
module sme_div import sme_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [WORD_W+1:0] trial;
  logic [WORD_W-1:0] mag_a, mag_b;

  assign mag_a = req.dividend[WORD_W-1] ? (~req.dividend + WORD_W'(1)) : req.dividend;
  assign mag_b = req.divisor[WORD_W-1]  ? (~req.divisor + WORD_W'(1))  : req.divisor;
  assign trial = {1'b0, rem_r, quo_r[WORD_W-1]} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      rem_nxt  = '0;
      quo_nxt  = mag_a;
      den_nxt  = mag_b;
      neg_nxt  = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the shifted value fits in one word.
      if (!trial[WORD_W+1]) begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = neg_r ? (~quo_r + WORD_W'(1)) : quo_r;

endmodule

>>> design/sme_back.sv
// Back end: operand stack memory, execution sequencer and result register.
module sme_back import sme_pkg::*; #(
  parameter int STACK_ENTRIES = STACK_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  dec_item_t q_item,
  output logic      q_pop,
  output div_req_t  div_req,
  input  div_rsp_t  div_rsp,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(STACK_ENTRIES);
  localparam int DW = $clog2(STACK_ENTRIES + 1);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DIV,
    S_DZ
  } state_t;

  logic [WORD_W-1:0] stack_mem [STACK_ENTRIES];
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  state_t            state_r;
  logic              halted_r;
  logic [DW-1:0]     depth_r;
  logic [WORD_W-1:0] top_r;
  op_t               op_r;
  logic [WORD_W-1:0] arg_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [DW-1:0]     depth_p1, depth_m1, depth_m2, depth_m3;
  logic [WORD_W-1:0] lhs, rhs, arith, mul_lo;
  logic              run_div, out_free, commit;

  err_t              ex_err;
  logic              ex_wr_en;
  logic [AW-1:0]     ex_wr_addr;
  logic [WORD_W-1:0] ex_wr_data;
  logic [DW-1:0]     ex_depth;
  logic [WORD_W-1:0] ex_top;
  logic [WORD_W-1:0] ex_popped;
  logic              ex_taken;
  logic [WORD_W-1:0] ex_offset;

  assign depth_p1 = depth_r + DW'(1);
  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);
  assign depth_m3 = depth_r - DW'(3);

  assign lhs    = rd_data_r;
  assign rhs    = top_r;
  assign mul_lo = lhs * rhs;

  always_comb begin
    unique case (op_r)
      OP_ADD:  arith = lhs + rhs;
      OP_SUB:  arith = lhs - rhs;
      OP_MUL:  arith = mul_lo;
      OP_DIV:  arith = div_rsp.quotient;
      default: arith = '0;
    endcase
  end

  assign run_div  = (state_r == S_RUN) && !halted_r && (op_r == OP_DIV) &&
                    (depth_r >= DW'(2));
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = out_free && (((state_r == S_RUN) && !run_div) ||
                                 ((state_r == S_DIV) && !div_rsp.busy) ||
                                 (state_r == S_DZ));

  // The top of stack is cached in top_r, so most operations need one memory read at most.
  always_comb begin
    ex_err     = ERR_OK;
    ex_wr_en   = 1'b0;
    ex_wr_addr = depth_r[AW-1:0];
    ex_wr_data = top_r;
    ex_depth   = depth_r;
    ex_top     = top_r;
    ex_popped  = '0;
    ex_taken   = 1'b0;
    ex_offset  = '0;
    if (halted_r) begin
      ex_err = ERR_HALTED;
    end else begin
      unique case (op_r)
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (depth_r < DW'(2)) begin
            ex_err = ERR_UNDERFLOW;
          end else if (state_r == S_DZ) begin
            // Both operands are consumed; the new top was fetched from below them.
            ex_err   = ERR_DIV_ZERO;
            ex_depth = depth_m2;
            ex_top   = (depth_m2 != '0) ? rd_data_r : '0;
          end else begin
            ex_wr_en   = 1'b1;
            ex_wr_addr = depth_m2[AW-1:0];
            ex_wr_data = arith;
            ex_depth   = depth_m1;
            ex_top     = arith;
          end
        end
        OP_PUSH: begin
          if (depth_r == DEPTH_FULL) begin
            ex_err = ERR_OVERFLOW;
          end else begin
            ex_wr_en   = 1'b1;
            ex_wr_data = arg_r;
            ex_depth   = depth_p1;
            ex_top     = arg_r;
          end
        end
        OP_POP, OP_IFZERO: begin
          if (depth_r == '0) begin
            ex_err = ERR_UNDERFLOW;
          end else begin
            ex_popped = top_r;
            ex_depth  = depth_m1;
            ex_top    = (depth_r >= DW'(2)) ? rd_data_r : '0;
            if ((op_r == OP_IFZERO) && (top_r == '0)) begin
              ex_taken  = 1'b1;
              ex_offset = arg_r;
            end
          end
        end
        OP_DUPE: begin
          if (depth_r == '0) begin
            ex_err = ERR_UNDERFLOW;
          end else if (depth_r == DEPTH_FULL) begin
            ex_err = ERR_OVERFLOW;
          end else begin
            ex_wr_en = 1'b1;
            ex_depth = depth_p1;
          end
        end
        OP_LOAD: begin
          if (!(arg_r < WORD_W'(depth_r))) begin
            ex_err = ERR_BAD_INDEX;
          end else if (depth_r == DEPTH_FULL) begin
            ex_err = ERR_OVERFLOW;
          end else begin
            ex_wr_en   = 1'b1;
            ex_wr_data = rd_data_r;
            ex_depth   = depth_p1;
            ex_top     = rd_data_r;
          end
        end
        OP_STORE: begin
          if (depth_r == '0) begin
            ex_err = ERR_UNDERFLOW;
          end else if (!(arg_r < WORD_W'(depth_m1))) begin
            ex_err = ERR_BAD_INDEX;
          end else begin
            // Storing into the entry just below the old top makes it the new top.
            ex_wr_en   = 1'b1;
            ex_wr_addr = arg_r[AW-1:0];
            ex_depth   = depth_m1;
            ex_top     = (arg_r == WORD_W'(depth_m2)) ? top_r : rd_data_r;
          end
        end
        OP_JUMP: begin
          ex_taken  = 1'b1;
          ex_offset = arg_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign q_pop   = (state_r == S_IDLE) && q_valid;
  assign rd_en   = q_pop || (run_div && (top_r == '0));
  assign rd_addr = !q_pop ? depth_m3[AW-1:0] :
                   (q_item.op == OP_LOAD) ? q_item.arg[AW-1:0] : depth_m2[AW-1:0];

  assign div_req.start    = run_div && (top_r != '0);
  assign div_req.dividend = lhs;
  assign div_req.divisor  = rhs;

  always_ff @(posedge clk) begin
    if (ex_wr_en && commit) begin
      stack_mem[ex_wr_addr] <= ex_wr_data;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      halted_r    <= 1'b0;
      depth_r     <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
        out_item_r  <= '{top_value:     ex_top,
                         popped_value:  ex_popped,
                         branch_taken:  ex_taken,
                         branch_offset: ex_offset,
                         stack_depth:   7'(ex_depth),
                         error_code:    ex_err};
        depth_r     <= ex_depth;
        top_r       <= ex_top;
        if ((ex_err != ERR_OK) && (ex_err != ERR_HALTED)) begin
          halted_r <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            op_r    <= q_item.op;
            arg_r   <= q_item.arg;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (run_div) begin
            state_r <= (top_r == '0) ? S_DZ : S_DIV;
          end else if (commit) begin
            state_r <= S_IDLE;
          end
        end
        S_DIV, S_DZ: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: front end, divider and back end.
//
// Each transaction on the input channel is one decoded instruction; each produces exactly one
// result transaction. Instructions pass through a two-entry queue in the front end, then the
// back end executes them one at a time against the operand stack memory, which has a single
// read port with registered read data and a cached top of stack. Most instructions pass through
// two back-end states, S_IDLE to read the stack and S_RUN to commit. A divide waits in S_DIV
// for the quotient from a one-bit-per-cycle divider; a divide by zero goes through S_DZ instead.
// The result register lets the next instruction start while a result waits on out_stall.
// After any error other than halted, every later instruction reports halted until reset.
module stack_machine_execute_unit import sme_pkg::*; #(
  parameter int STACK_ENTRIES = STACK_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      q_valid;
  dec_item_t q_item;
  logic      q_pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  sme_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sme_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sme_back #(
    .STACK_ENTRIES (STACK_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
